// ----- rtl/eth_ipv4_l4_header_parser_assert.svh -----
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_assert.svh
// Assertion macros used by the header parser checker.
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_L4_HEADER_PARSER_ASSERT_SVH
`define ETH_IPV4_L4_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EHP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("header parser check failed");

// next-cycle implication, sampled on clk, off during reset
`define EHP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("header parser check failed");

`endif

// ----- rtl/ehp_pkg.sv -----
// ----------------------------------------------------------------------------
// ehp_pkg
// Types and constants of the Ethernet / IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

	localparam int unsigned FRAME_MAX_DEF = 2048;

	localparam int unsigned ETH_HDR_BYTES = 14;
	localparam int unsigned POS_TYPE_HI = 12;
	localparam int unsigned POS_TYPE_LO = 13;
	localparam int unsigned POS_IP_VIHL = 14;
	localparam int unsigned POS_LEN_HI  = 16;
	localparam int unsigned POS_LEN_LO  = 17;
	localparam int unsigned POS_OFF_HI  = 20;
	localparam int unsigned POS_OFF_LO  = 21;
	localparam int unsigned POS_TTL     = 22;
	localparam int unsigned POS_PROTO   = 23;
	localparam int unsigned IP_HDR_END  = 24;

	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	localparam logic [2:0] ST_NOT_IPV4  = 3'd0;
	localparam logic [2:0] ST_FRAGMENT  = 3'd1;
	localparam logic [2:0] ST_OTHER     = 3'd2;
	localparam logic [2:0] ST_SRC_REJ   = 3'd3;
	localparam logic [2:0] ST_DST_REJ   = 3'd4;
	localparam logic [2:0] ST_TCP_OK    = 3'd5;
	localparam logic [2:0] ST_UDP_OK    = 3'd6;
	localparam logic [2:0] ST_TRUNCATED = 3'd7;

	localparam logic CFG_SRC_PORT = 1'b0;
	localparam logic CFG_DST_PORT = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] ether_type;
		logic [3:0]  ip_version;
		logic [5:0]  ip_header_bytes;
		logic [15:0] ip_total_length;
		logic [15:0] fragment_offset_bytes;
		logic [7:0]  time_to_live;
		logic [7:0]  ip_protocol;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [1:0]  tcp_flag_bits;
		logic [15:0] udp_length;
	} out_t;

	typedef struct packed {
		logic [6:0]  transport_start;
		logic [15:0] type_word;
		logic [7:0]  first_ip_byte;
		logic [15:0] length_word;
		logic [12:0] offset_word;
		logic [7:0]  ttl_byte;
		logic [7:0]  proto_byte;
		logic [31:0] port_pair;
		logic [15:0] flags_or_udp_len;
	} frame_st_t;

endpackage

// ----- rtl/ehp_capture.sv -----
// ----------------------------------------------------------------------------
// ehp_capture
// Per-frame byte counter and header field capture registers.
// ----------------------------------------------------------------------------
module ehp_capture #(
	parameter int unsigned FRAME_MAX = ehp_pkg::FRAME_MAX_DEF,
	parameter int unsigned POS_W     = $clog2(FRAME_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  ehp_pkg::in_t       item,
	output ehp_pkg::frame_st_t nxt,
	output logic [POS_W-1:0]   got
);
	import ehp_pkg::*;

	logic [POS_W-1:0] pos_q;
	frame_st_t        st_q;
	frame_st_t        st;
	logic             in_range;
	logic [POS_W-1:0] d;
	logic [7:0]       b;

	always_comb begin
		st       = st_q;
		b        = item.frame_byte;
		in_range = pos_q < POS_W'(FRAME_MAX);
		d        = '0;
		if (in_range) begin
			case (pos_q)
				POS_W'(POS_TYPE_HI): st.type_word[15:8] = b;
				POS_W'(POS_TYPE_LO): st.type_word[7:0] = b;
				POS_W'(POS_IP_VIHL): begin
					st.first_ip_byte   = b;
					st.transport_start = 7'(ETH_HDR_BYTES) + 7'({b[3:0], 2'b00});
				end
				POS_W'(POS_LEN_HI): st.length_word[15:8] = b;
				POS_W'(POS_LEN_LO): st.length_word[7:0] = b;
				POS_W'(POS_OFF_HI): st.offset_word[12:8] = b[4:0];
				POS_W'(POS_OFF_LO): st.offset_word[7:0] = b;
				POS_W'(POS_TTL):    st.ttl_byte = b;
				POS_W'(POS_PROTO):  st.proto_byte = b;
				default: ;
			endcase
			if (pos_q >= POS_W'(ETH_HDR_BYTES) && pos_q >= POS_W'(st.transport_start)) begin
				d = pos_q - POS_W'(st.transport_start);
				if (d < POS_W'(4)) begin
					case (d[1:0])
						2'd0:    st.port_pair[31:24] = b;
						2'd1:    st.port_pair[23:16] = b;
						2'd2:    st.port_pair[15:8]  = b;
						default: st.port_pair[7:0]   = b;
					endcase
				end
				if (d == POS_W'(4))
					st.flags_or_udp_len[15:8] = b;
				if (d == POS_W'(5))
					st.flags_or_udp_len[7:0] = b;
				if (d == POS_W'(13) && st.proto_byte == PROTO_TCP)
					st.flags_or_udp_len[7:0] = b;
			end
		end
		nxt = st;
		got = in_range ? pos_q + POS_W'(1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			st_q  <= '0;
		end else if (advance) begin
			if (item.frame_end) begin
				pos_q <= '0;
				st_q  <= '0;
			end else begin
				pos_q <= got;
				st_q  <= st;
			end
		end
	end

endmodule

// ----- rtl/ehp_classify.sv -----
// ----------------------------------------------------------------------------
// ehp_classify
// Frame classification and result field selection at end of frame.
// ----------------------------------------------------------------------------
module ehp_classify #(
	parameter int unsigned FRAME_MAX = ehp_pkg::FRAME_MAX_DEF,
	parameter int unsigned POS_W     = $clog2(FRAME_MAX + 1)
) (
	input  ehp_pkg::frame_st_t st,
	input  logic [POS_W-1:0]   got,
	input  logic [15:0]        src_match,
	input  logic [15:0]        dst_match,
	output ehp_pkg::out_t      res
);
	import ehp_pkg::*;

	logic [POS_W-1:0] s;
	logic [15:0]      sp;
	logic [15:0]      dp;
	logic [2:0]       code;

	always_comb begin
		s  = POS_W'(st.transport_start);
		sp = st.port_pair[31:16];
		dp = st.port_pair[15:0];
		if (st.offset_word != '0)
			code = ST_FRAGMENT;
		else if (st.proto_byte != PROTO_TCP && st.proto_byte != PROTO_UDP)
			code = ST_OTHER;
		else if (got < s + POS_W'(2))
			code = ST_TRUNCATED;
		else if (src_match != '0 && sp != src_match)
			code = ST_SRC_REJ;
		else if (got < s + POS_W'(4))
			code = ST_TRUNCATED;
		else if (dst_match != '0 && dp != dst_match)
			code = ST_DST_REJ;
		else if (st.proto_byte == PROTO_TCP)
			code = (got < s + POS_W'(14)) ? ST_TRUNCATED : ST_TCP_OK;
		else
			code = (got < s + POS_W'(6)) ? ST_TRUNCATED : ST_UDP_OK;

		res            = '0;
		res.ether_type = st.type_word;
		if (got < POS_W'(ETH_HDR_BYTES))
			res.status = ST_TRUNCATED;
		else if (st.type_word != TYPE_IPV4)
			res.status = ST_NOT_IPV4;
		else if (got < POS_W'(IP_HDR_END))
			res.status = ST_TRUNCATED;
		else begin
			res.status = code;
			if (code != ST_TRUNCATED) begin
				res.ip_version            = st.first_ip_byte[7:4];
				res.ip_header_bytes       = {st.first_ip_byte[3:0], 2'b00};
				res.ip_total_length       = st.length_word;
				res.fragment_offset_bytes = {st.offset_word, 3'b000};
				res.time_to_live          = st.ttl_byte;
				res.ip_protocol           = st.proto_byte;
				if (code >= ST_SRC_REJ)
					res.source_port = sp;
				if (code >= ST_DST_REJ)
					res.dest_port = dp;
				if (code == ST_TCP_OK)
					res.tcp_flag_bits = {st.flags_or_udp_len[4], st.flags_or_udp_len[1]};
				if (code == ST_UDP_OK)
					res.udp_length = st.flags_or_udp_len;
			end
		end
	end

endmodule

// ----- rtl/eth_ipv4_l4_header_parser.sv -----
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser
// Ethernet / IPv4 / TCP-UDP header parser, one frame byte per transaction.
//
//  channel   direction  handshake                    payload
//  byte      in         byte_valid / byte_ready      ehp_pkg::in_t
//  result    out        result_valid / result_ready  ehp_pkg::out_t
//  cfg       in         cfg_we                       cfg_index, cfg_data
//
// One byte per cycle while no held result stalls; each result is registered.
// The cost per byte is set by the field capture and classify logic between
// the input register and the result register.
// Reset clears the byte counter, the capture registers and both port filters.
// A held result keeps the last byte of the next frame in the input register
// and blocks further bytes until the result transaction completes.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser #(
	parameter int unsigned FRAME_MAX = ehp_pkg::FRAME_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  ehp_pkg::in_t  byte_data,
	output logic          result_valid,
	input  logic          result_ready,
	output ehp_pkg::out_t result_data,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);
	import ehp_pkg::*;

	localparam int unsigned POS_W = $clog2(FRAME_MAX + 1);

	logic             valid_s1;
	in_t              item_s1;
	logic             out_free;
	logic             advance;
	frame_st_t        nxt;
	logic [POS_W-1:0] got;
	out_t             res;
	logic [15:0]      src_match_q;
	logic [15:0]      dst_match_q;
	logic             out_valid_q;
	out_t             out_q;

	assign out_free   = !out_valid_q || result_ready;
	assign advance    = valid_s1 && (!item_s1.frame_end || out_free);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_match_q <= '0;
			dst_match_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_PORT: src_match_q <= cfg_data;
				CFG_DST_PORT: dst_match_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ehp_capture #(
		.FRAME_MAX(FRAME_MAX),
		.POS_W    (POS_W)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.nxt    (nxt),
		.got    (got)
	);

	ehp_classify #(
		.FRAME_MAX(FRAME_MAX),
		.POS_W    (POS_W)
	) u_classify (
		.st       (nxt),
		.got      (got),
		.src_match(src_match_q),
		.dst_match(dst_match_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.frame_end)
			out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

// ----- rtl/ehp_checker.sv -----
// ----------------------------------------------------------------------------
// ehp_checker
// Port-level checks of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "eth_ipv4_l4_header_parser_assert.svh"

module ehp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          result_valid,
	input logic          result_ready,
	input ehp_pkg::out_t result_data
);
	import ehp_pkg::*;

	`EHP_ASSERT_NEXT(a_hold_result, result_valid && !result_ready,
		result_valid && $stable(result_data))

	`EHP_ASSERT_NOW(a_not_ipv4_clear,
		result_valid && result_data.status == ST_NOT_IPV4,
		result_data.ip_version == '0 && result_data.ip_protocol == '0 &&
		result_data.source_port == '0 && result_data.udp_length == '0)

	`EHP_ASSERT_NOW(a_truncated_clear,
		result_valid && result_data.status == ST_TRUNCATED,
		result_data.ip_header_bytes == '0 && result_data.time_to_live == '0 &&
		result_data.dest_port == '0 && result_data.tcp_flag_bits == '0)

	`EHP_ASSERT_NOW(a_l4_exclusive,
		result_valid && (result_data.status == ST_TCP_OK || result_data.status == ST_UDP_OK),
		(result_data.status == ST_TCP_OK && result_data.udp_length == '0 &&
		 result_data.ip_protocol == PROTO_TCP) ||
		(result_data.status == ST_UDP_OK && result_data.tcp_flag_bits == '0 &&
		 result_data.ip_protocol == PROTO_UDP))

endmodule

bind eth_ipv4_l4_header_parser ehp_checker u_ehp_checker (.*);

// ----- tb/eth_ipv4_l4_header_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_test
// Self-checking bench for the Ethernet / IPv4 / L4 header parser. Frames are
// fed byte by byte with bursty valid and a stalling result consumer. A
// scoreboard tracks the header fields of each frame and compares its
// verdict with every result transaction. Port filters change between phases.
// ----------------------------------------------------------------------------
module eth_ipv4_l4_header_parser_test;
	import ehp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned BYTE_TARGET = 900;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned MIN_FRAMES  = 2;
	localparam int unsigned HOLD_FRAMES = 4;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned SETTLE      = 16;

	typedef enum int {
		PK_TCP,
		PK_UDP,
		PK_FRAGMENT,
		PK_OTHER_PROTO,
		PK_NOT_IPV4,
		PK_CUT,
		PK_NOISE,
		PK_OVERLONG
	} pkt_kind_e;

	class hdr_scoreboard;
		logic [15:0] src_filter;
		logic [15:0] dst_filter;
		int unsigned pos;
		logic [6:0]  l4_start;
		logic [15:0] type_word;
		logic [15:0] tot_len;
		logic [15:0] l4_word;
		logic [7:0]  vihl;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [12:0] frag_off;
		logic [31:0] ports;
		out_t        verdict_q[$];
		int unsigned fails;

		function new();
			src_filter = '0;
			dst_filter = '0;
			fails = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos = 0;
			l4_start = '0;
			type_word = '0;
			tot_len = '0;
			l4_word = '0;
			vihl = '0;
			ttl = '0;
			proto = '0;
			frag_off = '0;
			ports = '0;
		endfunction

		function void set_filter(logic idx, logic [15:0] val);
			if (idx == CFG_SRC_PORT) src_filter = val;
			else dst_filter = val;
		endfunction

		function int unsigned pending();
			return verdict_q.size();
		endfunction

		function void capture(int unsigned p, logic [7:0] b);
			int unsigned s;
			case (p)
				POS_TYPE_HI: type_word[15:8] = b;
				POS_TYPE_LO: type_word[7:0] = b;
				POS_IP_VIHL: begin
					vihl = b;
					l4_start = 7'(ETH_HDR_BYTES + 4 * b[3:0]);
				end
				POS_LEN_HI: tot_len[15:8] = b;
				POS_LEN_LO: tot_len[7:0] = b;
				POS_OFF_HI: frag_off[12:8] = b[4:0];
				POS_OFF_LO: frag_off[7:0] = b;
				POS_TTL: ttl = b;
				POS_PROTO: proto = b;
				default: ;
			endcase
			if (p < ETH_HDR_BYTES) return;
			s = l4_start;
			if (p >= s && p < s + 4) ports[8 * (3 - (p - s)) +: 8] = b;
			if (p == s + 4) l4_word[15:8] = b;
			if (p == s + 5) l4_word[7:0] = b;
			if (p == s + 13 && proto == PROTO_TCP) l4_word[7:0] = b;
		endfunction

		function out_t classify_frame();
			out_t r;
			int unsigned s;
			logic [15:0] sp;
			logic [15:0] dp;
			logic [2:0] st;
			r = '0;
			r.ether_type = type_word;
			s = l4_start;
			sp = ports[31:16];
			dp = ports[15:0];
			if (pos < ETH_HDR_BYTES) begin
				r.status = ST_TRUNCATED;
				return r;
			end
			if (type_word != TYPE_IPV4) begin
				r.status = ST_NOT_IPV4;
				return r;
			end
			if (pos < IP_HDR_END) begin
				r.status = ST_TRUNCATED;
				return r;
			end
			if (frag_off != 0) st = ST_FRAGMENT;
			else if (proto != PROTO_TCP && proto != PROTO_UDP) st = ST_OTHER;
			else if (pos < s + 2) st = ST_TRUNCATED;
			else if (src_filter != 0 && sp != src_filter) st = ST_SRC_REJ;
			else if (pos < s + 4) st = ST_TRUNCATED;
			else if (dst_filter != 0 && dp != dst_filter) st = ST_DST_REJ;
			else if (proto == PROTO_TCP) st = (pos < s + 14) ? ST_TRUNCATED : ST_TCP_OK;
			else st = (pos < s + 6) ? ST_TRUNCATED : ST_UDP_OK;
			r.status = st;
			if (st == ST_TRUNCATED) return r;
			r.ip_version = vihl[7:4];
			r.ip_header_bytes = {vihl[3:0], 2'b00};
			r.ip_total_length = tot_len;
			r.fragment_offset_bytes = {frag_off, 3'b000};
			r.time_to_live = ttl;
			r.ip_protocol = proto;
			if (st >= ST_SRC_REJ) r.source_port = sp;
			if (st >= ST_DST_REJ) r.dest_port = dp;
			if (st == ST_TCP_OK) r.tcp_flag_bits = {l4_word[4], l4_word[1]};
			if (st == ST_UDP_OK) r.udp_length = l4_word;
			return r;
		endfunction

		function void absorb_byte(in_t d);
			if (pos < FRAME_MAX_DEF) begin
				capture(pos, d.frame_byte);
				pos++;
			end
			if (d.frame_end) begin
				verdict_q.push_back(classify_frame());
				clear_frame();
			end
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		function void match_verdict(out_t got);
			out_t want;
			if (verdict_q.size() == 0) begin
				$error("result transaction with no frame outstanding, status %0d", got.status);
				fails++;
				return;
			end
			want = verdict_q.pop_front();
			check_field("status", want.status, got.status);
			check_field("ether_type", want.ether_type, got.ether_type);
			check_field("ip_version", want.ip_version, got.ip_version);
			check_field("ip_header_bytes", want.ip_header_bytes, got.ip_header_bytes);
			check_field("ip_total_length", want.ip_total_length, got.ip_total_length);
			check_field("fragment_offset_bytes", want.fragment_offset_bytes,
				got.fragment_offset_bytes);
			check_field("time_to_live", want.time_to_live, got.time_to_live);
			check_field("ip_protocol", want.ip_protocol, got.ip_protocol);
			check_field("source_port", want.source_port, got.source_port);
			check_field("dest_port", want.dest_port, got.dest_port);
			check_field("tcp_flag_bits", want.tcp_flag_bits, got.tcp_flag_bits);
			check_field("udp_length", want.udp_length, got.udp_length);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	in_t         byte_data;
	logic        result_valid;
	logic        result_ready;
	out_t        result_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	hdr_scoreboard sb;
	logic [7:0]    pkt[$];
	int unsigned   burst_left;
	bit            gaps_on;
	bit            hold_req;
	int unsigned   hold_left;
	int unsigned   rx_cycle;
	int unsigned   cycle_count;
	int unsigned   phase;
	int unsigned   phase_bytes;
	int unsigned   phase_frames;
	int unsigned   roll;
	int unsigned   ihl;
	pkt_kind_e     kind;

	eth_ipv4_l4_header_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.match_verdict(result_data);
	end

	initial begin
		result_ready = 1'b0;
		hold_left = 0;
		rx_cycle = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				case (rx_cycle[9:8])
					2'd0: result_ready <= 1'b1;
					2'd1: result_ready <= 1'($urandom_range(0, 1));
					2'd2: result_ready <= (rx_cycle[1:0] != 2'd0);
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			rx_cycle++;
		end
	end

	function automatic logic [15:0] pick_port(logic [15:0] filt);
		if (filt != 16'd0 && $urandom_range(0, 9) < 8) return filt;
		return 16'($urandom);
	endfunction

	function automatic void build_packet(pkt_kind_e k, int unsigned hl, int unsigned cut_len);
		int unsigned s;
		int unsigned full;
		logic [7:0]  pr;
		logic [15:0] etype;
		logic [15:0] sp;
		logic [15:0] dp;
		s = ETH_HDR_BYTES + 4 * hl;
		case (k)
			PK_UDP: pr = PROTO_UDP;
			PK_TCP, PK_OVERLONG: pr = PROTO_TCP;
			PK_OTHER_PROTO: begin
				pr = 8'($urandom);
				while (pr == PROTO_TCP || pr == PROTO_UDP) pr = 8'($urandom);
			end
			default: pr = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		endcase
		full = s + ((pr == PROTO_UDP) ? 8 : 20);
		if (full < IP_HDR_END) full = IP_HDR_END;
		full += $urandom_range(0, 12);
		if (k == PK_OVERLONG) full = FRAME_MAX_DEF + $urandom_range(1, 40);
		if (k == PK_NOISE) full = $urandom_range(1, 64);
		pkt.delete();
		repeat (full) pkt.push_back(8'($urandom));
		if (k != PK_NOISE) begin
			etype = TYPE_IPV4;
			if (k == PK_NOT_IPV4) begin
				case ($urandom_range(0, 3))
					0: etype = 16'h86DD;
					1: etype = 16'h0008;
					2: etype = 16'h0801;
					default: etype = 16'($urandom);
				endcase
			end
			pkt[POS_TYPE_HI] = etype[15:8];
			pkt[POS_TYPE_LO] = etype[7:0];
			pkt[POS_IP_VIHL] = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4, 4'(hl)};
			pkt[POS_OFF_HI] = {3'($urandom), 5'd0};
			pkt[POS_OFF_LO] = 8'd0;
			if (k == PK_FRAGMENT) begin
				if ($urandom_range(0, 1))
					pkt[POS_OFF_HI] = {3'($urandom), 5'($urandom_range(1, 31))};
				else
					pkt[POS_OFF_LO] = 8'($urandom_range(1, 255));
			end
			pkt[POS_PROTO] = pr;
			sp = pick_port(sb.src_filter);
			dp = pick_port(sb.dst_filter);
			pkt[s] = sp[15:8];
			pkt[s + 1] = sp[7:0];
			pkt[s + 2] = dp[15:8];
			pkt[s + 3] = dp[7:0];
		end
		if (k == PK_CUT && cut_len == 0)
			cut_len = $urandom_range(0, 1) ? s + $urandom_range(0, 14)
				: $urandom_range(1, full - 1);
		if (cut_len != 0) while (pkt.size() > cut_len) pkt.pop_back();
	endfunction

	task automatic send_byte(input in_t d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if (gaps_on) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_data <= d;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		sb.absorb_byte(d);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_packet();
		in_t d;
		for (int i = 0; i < pkt.size(); i++) begin
			d.frame_byte = pkt[i];
			d.frame_end = (i == pkt.size() - 1);
			send_byte(d);
		end
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_filter(idx, val);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_SRC_PORT;
		cfg_data = '0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_cfg(CFG_SRC_PORT, 16'h0000);
		write_cfg(CFG_DST_PORT, 16'h0000);

		pkt = {8'hFF};
		send_packet();
		pkt = {8'h00, 8'hFF, 8'h00};
		send_packet();
		build_packet(PK_TCP, 5, 13);
		send_packet();
		build_packet(PK_NOT_IPV4, 5, 14);
		send_packet();
		build_packet(PK_UDP, 5, 20);
		send_packet();
		build_packet(PK_TCP, 5, 0);
		send_packet();
		build_packet(PK_UDP, 15, 0);
		send_packet();
		build_packet(PK_TCP, 0, 0);
		send_packet();
		build_packet(PK_UDP, 3, 0);
		send_packet();
		build_packet(PK_FRAGMENT, 5, 0);
		send_packet();
		build_packet(PK_OTHER_PROTO, 5, 0);
		send_packet();
		build_packet(PK_TCP, 5, ETH_HDR_BYTES + 22);
		send_packet();
		build_packet(PK_UDP, 5, ETH_HDR_BYTES + 25);
		send_packet();

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					write_cfg(CFG_SRC_PORT, 16'h0000);
					write_cfg(CFG_DST_PORT, 16'h0000);
				end
				1: begin
					write_cfg(CFG_SRC_PORT, 16'hFFFF);
					write_cfg(CFG_DST_PORT, 16'hFFFF);
				end
				2: begin
					write_cfg(CFG_SRC_PORT, 16'($urandom_range(1, 65535)));
					write_cfg(CFG_DST_PORT, 16'h0000);
				end
				3: begin
					write_cfg(CFG_SRC_PORT, 16'h0000);
					write_cfg(CFG_DST_PORT, 16'($urandom_range(1, 65535)));
				end
				4: begin
					write_cfg(CFG_SRC_PORT, 16'h0001);
					write_cfg(CFG_DST_PORT, 16'hFFFF);
				end
				default: begin
					write_cfg(CFG_SRC_PORT, 16'($urandom_range(1, 65535)));
					write_cfg(CFG_DST_PORT, 16'($urandom_range(1, 65535)));
				end
			endcase
			// stall the consumer while frames keep coming
			if (phase == 2) hold_req = 1'b1;
			phase_bytes = 0;
			phase_frames = 0;
			while (phase_bytes < BYTE_TARGET / PHASES || phase_frames < MIN_FRAMES ||
				(phase == 2 && phase_frames < HOLD_FRAMES)) begin
				roll = $urandom_range(0, 99);
				if (roll < 30) kind = PK_TCP;
				else if (roll < 55) kind = PK_UDP;
				else if (roll < 68) kind = PK_CUT;
				else if (roll < 76) kind = PK_FRAGMENT;
				else if (roll < 84) kind = PK_OTHER_PROTO;
				else if (roll < 92) kind = PK_NOT_IPV4;
				else kind = PK_NOISE;
				ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
				build_packet(kind, ihl, 0);
				gaps_on = ($urandom_range(0, 3) != 0);
				send_packet();
				phase_bytes += pkt.size();
				phase_frames++;
				if ($urandom_range(0, 19) == 0) drain_results();
			end
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (sb.fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ehp_pkg.sv
rtl/ehp_capture.sv
rtl/ehp_classify.sv
rtl/eth_ipv4_l4_header_parser.sv
rtl/ehp_checker.sv
tb/eth_ipv4_l4_header_parser_test.sv
